// ===== sv/dtn_pkg.sv =====
// Shared types and constants of the decimal text to number converter.
// Holds the result kind codes, the parsed job record and the powers-of-ten table.
// No dependencies.
package dtn_pkg;

    typedef enum logic [1:0]
    {
        KIND_INT    = 2'd0,
        KIND_DOUBLE = 2'd1,
        KIND_NAN    = 2'd2,
        KIND_INF    = 2'd3
    } kind_t;

    // Eighteen decimal digits always fit below two to the sixtieth.
    localparam int MANT_W      = 60;
    localparam int MAG_FIELD_W = 9;
    localparam int TEN_IDX_W   = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [62:0] DBL_ONE     = 63'h3FF0000000000000;
    localparam logic [62:0] DBL_INF_MAG = {11'h7FF, 52'd0};

    typedef struct packed
    {
        kind_t                  kind;
        logic                   neg;
        logic [MANT_W-1:0]      mant;
        logic                   e_neg;
        logic [MAG_FIELD_W-1:0] mag;
    } dtn_job_t;

    // Binary64 magnitudes of ten raised to successive powers of two.
    function automatic logic [62:0] ten_pow2(input logic [TEN_IDX_W-1:0] idx);
        logic [63:0] v;
        case (idx)
            4'd0:    v = 64'h4024000000000000;
            4'd1:    v = 64'h4059000000000000;
            4'd2:    v = 64'h40C3880000000000;
            4'd3:    v = 64'h4197D78400000000;
            4'd4:    v = 64'h4341C37937E08000;
            4'd5:    v = 64'h4693B8B5B5056E17;
            4'd6:    v = 64'h4D384F03E93FF9F5;
            4'd7:    v = 64'h5A827748F9301D32;
            4'd8:    v = 64'h75154FDD7F73BF3C;
            default: v = 64'h0;
        endcase
        return v[62:0];
    endfunction

endpackage

// ===== sv/dtn_front.sv =====
// Character parser: takes one character per item and builds a job per text.
// Depends on dtn_pkg.
module dtn_front #(
    parameter int MANTISSA_DIGITS = 18,
    parameter int MAX_EXPONENT    = 511
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              valid,
    output logic              ready,
    input  logic [7:0]        char_code,
    input  logic              last_char,
    input  logic              q_full,
    output logic              push,
    output dtn_pkg::dtn_job_t job
);
    import dtn_pkg::*;

    localparam int KEPT_W = $clog2(MANTISSA_DIGITS + 1);
    localparam logic signed [11:0] FS_MIN = 12'sh800;
    localparam logic signed [11:0] FS_MAX = 12'sh7FF;

    typedef enum logic [2:0]
    {
        PH_LEAD, PH_MANT, PH_EXP_START, PH_EXP_SIGN, PH_EXP_DIG, PH_TRAIL, PH_TRAIL_EXP
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic                minus_reg, minus_next;
    logic [MANT_W-1:0]   mant_reg, mant_next;
    logic [KEPT_W-1:0]   kept_reg, kept_next;
    logic                point_reg, point_next;
    logic signed [11:0]  fs_reg, fs_next;
    logic [9:0]          eacc_reg, eacc_next;
    logic                eminus_reg, eminus_next;
    logic                err_reg, err_next;

    logic accept;
    logic is_blank, is_digit, is_sign, is_minus, is_dot, is_e;
    logic [3:0] dval;

    assign ready    = !q_full;
    assign accept   = valid && ready;
    assign push     = accept && last_char;
    assign is_blank = (char_code == 8'd32) || (char_code >= 8'd9 && char_code <= 8'd13);
    assign is_digit = (char_code >= 8'h30) && (char_code <= 8'h39);
    assign is_minus = (char_code == 8'h2D);
    assign is_sign  = is_minus || (char_code == 8'h2B);
    assign is_dot   = (char_code == 8'h2E);
    assign is_e     = (char_code == 8'h45) || (char_code == 8'h65);
    assign dval     = char_code[3:0];

    always_comb
    begin
        logic              do_mant;
        logic              do_edig;
        logic [13:0]       etmp;
        logic              exp_given;
        logic signed [12:0] e13;
        logic signed [12:0] mag13;
        phase_next  = phase_reg;
        minus_next  = minus_reg;
        mant_next   = mant_reg;
        kept_next   = kept_reg;
        point_next  = point_reg;
        fs_next     = fs_reg;
        eacc_next   = eacc_reg;
        eminus_next = eminus_reg;
        err_next    = err_reg;
        do_mant     = 1'b0;
        do_edig     = 1'b0;
        etmp        = '0;
        if (!err_reg)
        begin
            unique case (phase_reg)
                PH_LEAD:
                begin
                    if (is_sign)
                    begin
                        minus_next = is_minus;
                        phase_next = PH_MANT;
                    end
                    else if (!is_blank)
                        do_mant = 1'b1;
                end
                PH_MANT:
                    do_mant = 1'b1;
                PH_EXP_START:
                begin
                    if (is_sign)
                    begin
                        eminus_next = is_minus;
                        phase_next  = PH_EXP_SIGN;
                    end
                    else if (is_digit)
                    begin
                        do_edig    = 1'b1;
                        phase_next = PH_EXP_DIG;
                    end
                    else
                        err_next = 1'b1;
                end
                PH_EXP_SIGN:
                begin
                    if (is_digit)
                    begin
                        do_edig    = 1'b1;
                        phase_next = PH_EXP_DIG;
                    end
                    else
                        err_next = 1'b1;
                end
                PH_EXP_DIG:
                begin
                    if (is_digit)
                        do_edig = 1'b1;
                    else if (is_blank)
                        phase_next = PH_TRAIL_EXP;
                    else
                        err_next = 1'b1;
                end
                PH_TRAIL, PH_TRAIL_EXP:
                begin
                    if (!is_blank)
                        err_next = 1'b1;
                end
                default:
                    err_next = 1'b1;
            endcase

            if (do_mant)
            begin
                phase_next = PH_MANT;
                if (is_digit)
                begin
                    if (kept_reg < KEPT_W'(MANTISSA_DIGITS))
                    begin
                        mant_next = (mant_reg << 3) + (mant_reg << 1) + {{(MANT_W-4){1'b0}}, dval};
                        kept_next = kept_reg + 1'b1;
                        if (point_reg && fs_reg != FS_MIN)
                            fs_next = fs_reg - 12'sd1;
                    end
                    else if (!point_reg && fs_reg != FS_MAX)
                        fs_next = fs_reg + 12'sd1;
                end
                else if (is_dot && !point_reg)
                    point_next = 1'b1;
                else if (is_e && kept_reg != '0)
                    phase_next = PH_EXP_START;
                else if (is_blank)
                    phase_next = PH_TRAIL;
                else
                    err_next = 1'b1;
            end

            if (do_edig)
            begin
                etmp = ({4'd0, eacc_reg} << 3) + ({4'd0, eacc_reg} << 1) + {10'd0, dval};
                eacc_next = (etmp > 14'd1023) ? 10'd1023 : etmp[9:0];
            end
        end

        // Classification of the finished text, from the values after this character.
        // The reported sign is the one seen before it, so a text that ends on its sign
        // is reported as positive.
        exp_given = (phase_next == PH_EXP_DIG) || (phase_next == PH_TRAIL_EXP);
        e13   = {fs_next[11], fs_next} +
                (eminus_next ? -$signed({3'b000, eacc_next}) : $signed({3'b000, eacc_next}));
        mag13 = (e13 < 0) ? -e13 : e13;
        job.mant  = mant_next;
        job.e_neg = e13 < 0;
        job.mag   = mag13[MAG_FIELD_W-1:0];
        job.neg   = minus_reg;
        if (err_next || phase_next == PH_EXP_START || phase_next == PH_EXP_SIGN)
        begin
            job.kind = KIND_NAN;
            job.neg  = 1'b0;
        end
        else if (!point_next && !exp_given && fs_next == 12'sd0)
            job.kind = KIND_INT;
        else if (mag13 > 13'(MAX_EXPONENT))
            job.kind = KIND_INF;
        else
            job.kind = KIND_DOUBLE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_LEAD;
            minus_reg  <= 1'b0;
            mant_reg   <= '0;
            kept_reg   <= '0;
            point_reg  <= 1'b0;
            fs_reg     <= 12'sd0;
            eacc_reg   <= '0;
            eminus_reg <= 1'b0;
            err_reg    <= 1'b0;
        end
        else if (accept)
        begin
            if (last_char)
            begin
                phase_reg  <= PH_LEAD;
                minus_reg  <= 1'b0;
                mant_reg   <= '0;
                kept_reg   <= '0;
                point_reg  <= 1'b0;
                fs_reg     <= 12'sd0;
                eacc_reg   <= '0;
                eminus_reg <= 1'b0;
                err_reg    <= 1'b0;
            end
            else
            begin
                phase_reg  <= phase_next;
                minus_reg  <= minus_next;
                mant_reg   <= mant_next;
                kept_reg   <= kept_next;
                point_reg  <= point_next;
                fs_reg     <= fs_next;
                eacc_reg   <= eacc_next;
                eminus_reg <= eminus_next;
                err_reg    <= err_next;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg && !(accept && last_char) |=> err_reg)
        else $error("syntax error flag dropped within a text");
`endif

endmodule

// ===== sv/dtn_queue.sv =====
// Short job queue between the parser and the arithmetic sequencer.
// Depends on dtn_pkg.
module dtn_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  dtn_pkg::dtn_job_t push_job,
    input  logic              pop,
    output logic              valid,
    output dtn_pkg::dtn_job_t job,
    output logic              full
);
    import dtn_pkg::*;

    // Depth is a power of two, so the pointers wrap by themselves.
    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    dtn_job_t           entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign valid = count_reg != '0;
    assign full  = count_reg == CNT_W'(QUEUE_DEPTH);
    assign job   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("job queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> valid)
        else $error("job queue read while empty");
`endif

endmodule

// ===== sv/dtn_back.sv =====
// Arithmetic sequencer: turns a parsed job into the result item, using a
// shift-add multiplier, a restoring divider and a shared rounding step.
// Depends on dtn_pkg.
module dtn_back #(
    parameter int MAX_EXPONENT = 511
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  dtn_pkg::dtn_job_t q_job,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output dtn_pkg::kind_t    out_kind,
    output logic              out_neg,
    output logic [63:0]       out_bits
);
    import dtn_pkg::*;

    localparam int MAG_W     = $clog2(MAX_EXPONENT + 1);
    localparam int MUL_STEPS = 53;
    localparam int DIV_STEPS = 56;

    typedef enum logic [2:0]
    {
        ST_IDLE, ST_NORM, ST_RND, ST_SCALE, ST_MUL, ST_DIV, ST_CLASS, ST_DONE
    } state_t;

    typedef enum logic [1:0]
    {
        RET_MANT, RET_SCALE, RET_FINAL
    } ret_t;

    state_t              state_reg, state_next;
    ret_t                ret_reg, ret_next;
    logic [5:0]          cnt_reg, cnt_next;
    logic [TEN_IDX_W-1:0] idx_reg, idx_next;
    logic                neg_reg, neg_next;
    logic                eneg_reg, eneg_next;
    logic [MAG_W-1:0]    mag_reg, mag_next;
    logic [MANT_W-1:0]   mant_reg, mant_next;
    logic [62:0]         mbits_reg, mbits_next;
    logic [62:0]         scale_reg, scale_next;
    logic [52:0]         opa_reg, opa_next;
    logic [105:0]        prod_reg, prod_next;
    logic [53:0]         rem_reg, rem_next;
    logic [52:0]         dvs_reg, dvs_next;
    logic [55:0]         quo_reg, quo_next;
    logic signed [12:0]  exp_reg, exp_next;
    logic [55:0]         rx_reg, rx_next;
    logic                rs_reg, rs_next;
    logic [62:0]         res_reg, res_next;
    kind_t               rkind_reg, rkind_next;
    logic [63:0]         rbits_reg, rbits_next;
    logic                out_valid_reg, out_valid_next;
    kind_t               out_kind_reg, out_kind_next;
    logic                out_neg_reg, out_neg_next;
    logic [63:0]         out_bits_reg, out_bits_next;

    logic [52:0]         m_sig, s_sig, t_sig;
    logic signed [12:0]  m_exp, s_exp, t_exp;
    logic [62:0]         ten_bits;
    logic [53:0]         mul_sum;
    logic                div_ge;
    logic [53:0]         div_diff;
    logic [62:0]         rnd;

    function automatic logic signed [12:0] unpack_exp(input logic [62:0] b);
        return $signed({2'b00, b[62:52]}) - 13'sd1023;
    endfunction

    // Round a value x * 2^(e-55), leading one at bit 55, to binary64 with
    // ties to even; values below the normal range are denormalised first.
    function automatic logic [62:0] round_pack(input logic [55:0] x,
                                               input logic signed [12:0] e,
                                               input logic s);
        logic signed [12:0] biased;
        logic signed [12:0] k13;
        logic [55:0]        y;
        logic [55:0]        lowmask;
        logic [10:0]        field;
        logic               st;
        logic               inc;
        logic [5:0]         k;
        logic [62:0]        r;
        biased  = e + 13'sd1023;
        field   = '0;
        y       = x;
        st      = s;
        inc     = 1'b0;
        k       = '0;
        lowmask = '0;
        k13     = '0;
        if (biased >= 13'sd2047)
            r = DBL_INF_MAG;
        else
        begin
            if (biased >= 13'sd1)
                field = biased[10:0];
            else
            begin
                k13 = 13'sd1 - biased;
                if (k13 > 13'sd55)
                begin
                    y  = '0;
                    st = s | (|x);
                end
                else
                begin
                    k       = k13[5:0];
                    lowmask = (56'd1 << k) - 56'd1;
                    y       = x >> k;
                    st      = s | (|(x & lowmask));
                end
            end
            inc = y[2] & (y[3] | y[1] | y[0] | st);
            r   = {field, y[54:3]} + {62'd0, inc};
        end
        return r;
    endfunction

    assign ten_bits = ten_pow2(idx_reg);
    assign m_sig    = {1'b1, mbits_reg[51:0]};
    assign s_sig    = {1'b1, scale_reg[51:0]};
    assign t_sig    = {1'b1, ten_bits[51:0]};
    assign m_exp    = unpack_exp(mbits_reg);
    assign s_exp    = unpack_exp(scale_reg);
    assign t_exp    = unpack_exp(ten_bits);

    assign mul_sum  = {1'b0, prod_reg[105:53]} + (prod_reg[0] ? {1'b0, opa_reg} : 54'd0);
    assign div_ge   = rem_reg >= {1'b0, dvs_reg};
    assign div_diff = div_ge ? (rem_reg - {1'b0, dvs_reg}) : rem_reg;
    assign rnd      = round_pack(rx_reg, exp_reg, rs_reg);

    assign q_pop     = (state_reg == ST_IDLE) && q_valid;
    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_neg   = out_neg_reg;
    assign out_bits  = out_bits_reg;

    always_comb
    begin
        logic [10:0] cf;
        logic [51:0] cfrac;
        logic [52:0] csig;
        logic [5:0]  csh;
        logic [5:0]  crs;
        logic [51:0] cmask;
        logic [63:0] cival;
        logic        cint;
        state_next     = state_reg;
        ret_next       = ret_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        neg_next       = neg_reg;
        eneg_next      = eneg_reg;
        mag_next       = mag_reg;
        mant_next      = mant_reg;
        mbits_next     = mbits_reg;
        scale_next     = scale_reg;
        opa_next       = opa_reg;
        prod_next      = prod_reg;
        rem_next       = rem_reg;
        dvs_next       = dvs_reg;
        quo_next       = quo_reg;
        exp_next       = exp_reg;
        rx_next        = rx_reg;
        rs_next        = rs_reg;
        res_next       = res_reg;
        rkind_next     = rkind_reg;
        rbits_next     = rbits_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_kind_next  = out_kind_reg;
        out_neg_next   = out_neg_reg;
        out_bits_next  = out_bits_reg;
        cf    = res_reg[62:52];
        cfrac = res_reg[51:0];
        csig  = {1'b1, cfrac};
        csh   = '0;
        crs   = '0;
        cmask = '0;
        cival = '0;
        cint  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    neg_next  = q_job.neg;
                    eneg_next = q_job.e_neg;
                    mag_next  = q_job.mag[MAG_W-1:0];
                    rbits_next = '0;
                    unique case (q_job.kind)
                        KIND_NAN:
                        begin
                            rkind_next = KIND_NAN;
                            neg_next   = 1'b0;
                            state_next = ST_DONE;
                        end
                        KIND_INF:
                        begin
                            rkind_next = KIND_INF;
                            state_next = ST_DONE;
                        end
                        KIND_INT:
                        begin
                            rkind_next = KIND_INT;
                            rbits_next = q_job.neg ? -{4'd0, q_job.mant} : {4'd0, q_job.mant};
                            state_next = ST_DONE;
                        end
                        KIND_DOUBLE:
                        begin
                            if (q_job.mant == '0)
                            begin
                                rkind_next = KIND_INT;
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                mant_next  = q_job.mant;
                                exp_next   = 13'(MANT_W - 1);
                                state_next = ST_NORM;
                            end
                        end
                    endcase
                end
            end
            ST_NORM:
            begin
                if (mant_reg[MANT_W-1])
                begin
                    rx_next    = mant_reg[MANT_W-1:MANT_W-56];
                    rs_next    = |mant_reg[MANT_W-57:0];
                    ret_next   = RET_MANT;
                    state_next = ST_RND;
                end
                else
                begin
                    mant_next = mant_reg << 1;
                    exp_next  = exp_reg - 13'sd1;
                end
            end
            ST_RND:
            begin
                unique case (ret_reg)
                    RET_MANT:
                    begin
                        mbits_next = rnd;
                        scale_next = DBL_ONE;
                        idx_next   = '0;
                        state_next = ST_SCALE;
                    end
                    RET_SCALE:
                    begin
                        scale_next = rnd;
                        state_next = ST_SCALE;
                    end
                    RET_FINAL:
                    begin
                        res_next   = rnd;
                        state_next = ST_CLASS;
                    end
                    default:
                        state_next = ST_CLASS;
                endcase
            end
            ST_SCALE:
            begin
                cnt_next = '0;
                if (idx_reg == TEN_IDX_W'(MAG_W))
                begin
                    if (eneg_reg)
                    begin
                        if (scale_reg[62:52] == 11'h7FF)
                        begin
                            // Dividing by an infinite scale leaves zero.
                            res_next   = '0;
                            state_next = ST_CLASS;
                        end
                        else
                        begin
                            rem_next   = {1'b0, m_sig};
                            dvs_next   = s_sig;
                            quo_next   = '0;
                            exp_next   = m_exp - s_exp;
                            state_next = ST_DIV;
                        end
                    end
                    else
                    begin
                        opa_next   = m_sig;
                        prod_next  = {53'd0, s_sig};
                        exp_next   = m_exp + s_exp;
                        ret_next   = RET_FINAL;
                        state_next = ST_MUL;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    mag_next = mag_reg >> 1;
                    if (mag_reg[0])
                    begin
                        opa_next   = s_sig;
                        prod_next  = {53'd0, t_sig};
                        exp_next   = s_exp + t_exp;
                        ret_next   = RET_SCALE;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                if (cnt_reg == 6'(MUL_STEPS))
                begin
                    if (prod_reg[105])
                    begin
                        rx_next  = prod_reg[105:50];
                        rs_next  = |prod_reg[49:0];
                        exp_next = exp_reg + 13'sd1;
                    end
                    else
                    begin
                        rx_next = prod_reg[104:49];
                        rs_next = |prod_reg[48:0];
                    end
                    state_next = ST_RND;
                end
                else
                begin
                    prod_next = {mul_sum, prod_reg[52:1]};
                    cnt_next  = cnt_reg + 1'b1;
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == 6'(DIV_STEPS))
                begin
                    if (quo_reg[55])
                        rx_next = quo_reg;
                    else
                    begin
                        rx_next  = {quo_reg[54:0], 1'b0};
                        exp_next = exp_reg - 13'sd1;
                    end
                    rs_next    = rem_reg != '0;
                    ret_next   = RET_FINAL;
                    state_next = ST_RND;
                end
                else
                begin
                    quo_next = {quo_reg[54:0], div_ge};
                    rem_next = {div_diff[52:0], 1'b0};
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_CLASS:
            begin
                // A finite double that is whole and fits 64 signed bits is an integer.
                if (res_reg == '0)
                    cint = 1'b1;
                else if (cf >= 11'd1023 && cf < 11'd1086)
                begin
                    csh = 6'(cf - 11'd1023);
                    if (csh >= 6'd52)
                    begin
                        cint  = 1'b1;
                        cival = {11'd0, csig} << (csh - 6'd52);
                    end
                    else
                    begin
                        crs   = 6'd52 - csh;
                        cmask = (52'd1 << crs) - 52'd1;
                        if ((cfrac & cmask) == '0)
                        begin
                            cint  = 1'b1;
                            cival = {11'd0, csig >> crs};
                        end
                    end
                end
                else if (cf == 11'd1086 && cfrac == '0 && neg_reg)
                begin
                    cint  = 1'b1;
                    cival = 64'h8000000000000000;
                end
                rkind_next = cint ? KIND_INT : KIND_DOUBLE;
                rbits_next = cint ? (neg_reg ? -cival : cival) : {neg_reg, res_reg};
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = rkind_reg;
                    out_neg_next   = neg_reg;
                    out_bits_next  = rbits_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ret_reg       <= RET_MANT;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            neg_reg       <= 1'b0;
            eneg_reg      <= 1'b0;
            mag_reg       <= '0;
            mant_reg      <= '0;
            mbits_reg     <= '0;
            scale_reg     <= '0;
            opa_reg       <= '0;
            prod_reg      <= '0;
            rem_reg       <= '0;
            dvs_reg       <= '0;
            quo_reg       <= '0;
            exp_reg       <= '0;
            rx_reg        <= '0;
            rs_reg        <= 1'b0;
            res_reg       <= '0;
            rkind_reg     <= KIND_INT;
            rbits_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_kind_reg  <= KIND_INT;
            out_neg_reg   <= 1'b0;
            out_bits_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            neg_reg       <= neg_next;
            eneg_reg      <= eneg_next;
            mag_reg       <= mag_next;
            mant_reg      <= mant_next;
            mbits_reg     <= mbits_next;
            scale_reg     <= scale_next;
            opa_reg       <= opa_next;
            prod_reg      <= prod_next;
            rem_reg       <= rem_next;
            dvs_reg       <= dvs_next;
            quo_reg       <= quo_next;
            exp_reg       <= exp_next;
            rx_reg        <= rx_next;
            rs_reg        <= rs_next;
            res_reg       <= res_next;
            rkind_reg     <= rkind_next;
            rbits_reg     <= rbits_next;
            out_valid_reg <= out_valid_next;
            out_kind_reg  <= out_kind_next;
            out_neg_reg   <= out_neg_next;
            out_bits_reg  <= out_bits_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_norm_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_NORM |-> mant_reg != '0)
        else $error("normalising a zero mantissa");
    a_nan_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && rkind_reg == KIND_NAN) |-> (rbits_reg == '0 && !neg_reg))
        else $error("not-a-number result carries a value or a sign");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> state_reg != ST_IDLE)
        else $error("job taken but sequencer stayed idle");
`endif

endmodule

// ===== sv/decimal_text_to_number_core.sv =====
// Top level of the decimal text to number converter.
// Depends on dtn_pkg, dtn_front, dtn_queue and dtn_back.
//
//  channel | direction | handshake         | contents
//  s_      | in        | s_tvalid/s_tready | one character, s_tlast on the final one
//  m_      | out       | m_tvalid/m_tready | one result item per text
//
// Characters are taken one per cycle while the queue is not full; the job of a text is
// written into the queue as its final character is taken. Integer, not-a-number and
// infinite results go from the idle state straight to the output state of the sequencer;
// a double is normalised and rounded, scaled by one power-of-ten multiplication per set
// exponent bit (at most 9), then given a final multiply or divide, a rounding step and a
// classification step before output; the multiplier and divider handle one bit per cycle.
// Reset clears all control state at once; there is no clearing pass.
// Two parsed texts can wait in the queue; s_tready falls only while it is full.
module decimal_text_to_number_core #(
    parameter int MANTISSA_DIGITS = 18,
    parameter int MAX_EXPONENT    = 511
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [0] is_negative, [64:1] value_bits, [71:65] zero
    output logic [1:0]  m_tuser    // [1:0] kind
);
    import dtn_pkg::*;

    dtn_job_t    push_job, q_job;
    logic        push, q_valid, q_full, q_pop;
    kind_t       out_kind;
    logic        out_neg;
    logic [63:0] out_bits;

    dtn_front #(
        .MANTISSA_DIGITS (MANTISSA_DIGITS),
        .MAX_EXPONENT    (MAX_EXPONENT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (s_tvalid),
        .ready     (s_tready),
        .char_code (s_tdata),
        .last_char (s_tlast),
        .q_full    (q_full),
        .push      (push),
        .job       (push_job)
    );

    dtn_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (q_pop),
        .valid    (q_valid),
        .job      (q_job),
        .full     (q_full)
    );

    dtn_back #(
        .MAX_EXPONENT (MAX_EXPONENT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_job     (q_job),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_kind  (out_kind),
        .out_neg   (out_neg),
        .out_bits  (out_bits)
    );

    assign m_tdata = {7'd0, out_bits, out_neg};
    assign m_tuser = out_kind;

endmodule
